[design/kart_pkg.sv]
// kart_pkg: shared constants for the key auto-repeat tracker
// used by key_auto_repeat_tracker_top, key_flags_checker and tb_top; no dependencies
package kart_pkg;

    // key store geometry
    localparam int NUM_KEYS = 256;
    localparam int ADDR_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // field widths
    localparam int KEY_W   = 8;
    localparam int COUNT_W = 8;
    localparam int DELAY_W = 8;

    // counter values with a special meaning
    localparam logic [COUNT_W:0]   FIRST_COUNT  = (COUNT_W+1)'(1);
    localparam logic [COUNT_W:0]   RELOAD_COUNT = (COUNT_W+1)'(2);
    localparam logic [DELAY_W-1:0] DELAY_RESET  = DELAY_W'(24);

endpackage

[design/kart_ram.sv]
// kart_ram: generic single-clock ram, one write and one read port
// read data registered, held while read enable is low; no dependencies
module kart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/key_auto_repeat_tracker_top.sv]
// key_auto_repeat_tracker_top: per-key hold counters with typematic repeat flags
// depends on kart_pkg and kart_ram
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready      | i_key_index, i_key_down, i_has_focus,
//           |                              | i_pointer_inside
//  out      | o_out_valid / i_out_ready    | o_key_echo, o_pressed, o_triggered,
//           |                              | o_repeated, o_clicked
//  cfg      | i_cfg_we (no wait)           | i_cfg_wdata (repeat delay)
//
// one transaction per cycle sustained while the output is not stalled; each sample
// passes the registered ram read into the update stage, then the output register.
// back-to-back samples of the same key are forwarded from the pending write.
// reset clears the valid bit of every key at once: no clearing pass needed.
// a stall on the output holds the update stage; input ready then drops.
module key_auto_repeat_tracker_top
    import kart_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DELAY_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic               i_key_down,
    input  logic               i_has_focus,
    input  logic               i_pointer_inside,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [KEY_W-1:0]   o_key_echo,
    output logic               o_pressed,
    output logic               o_triggered,
    output logic               o_repeated,
    output logic               o_clicked
);

    // configuration
    logic [DELAY_W-1:0] r_delay;

    // update stage
    logic               r_s1_vld;
    logic [KEY_W-1:0]   r_s1_key;
    logic               r_s1_in_store;
    logic               r_s1_down;
    logic               r_s1_inside;
    logic               r_s1_kvld;
    logic               r_s1_fwd;
    logic [COUNT_W-1:0] r_s1_fwd_cnt;

    // output register
    logic               r_o_vld;
    logic [KEY_W-1:0]   r_o_key;
    logic               r_o_pressed;
    logic               r_o_trig;
    logic               r_o_rep;
    logic               r_o_click;

    logic               r_kvld [NUM_KEYS];

    logic               in_acc;
    logic               out_free;
    logic               s1_adv;
    logic               in_store;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  s1_addr;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] old_cnt;
    logic [COUNT_W:0]   n_cnt;
    logic               s1_we;
    logic               n_pressed;
    logic               n_trig;
    logic               n_rep;
    logic               n_click;

    // handshake
    assign out_free   = !r_o_vld || i_out_ready;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_ready = !r_s1_vld || out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_store = 32'(i_key_index) < NUM_KEYS;
    assign in_addr  = ADDR_W'(i_key_index);
    assign s1_addr  = ADDR_W'(r_s1_key);
    assign s1_we    = s1_adv && r_s1_in_store;

    // counter store
    kart_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_KEYS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (s1_addr),
        .i_wdata (n_cnt[COUNT_W-1:0]),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // old count: forwarded write, else ram if written since reset, else zero
    always_comb begin
        if (r_s1_fwd) begin
            old_cnt = r_s1_fwd_cnt;
        end else if (r_s1_kvld) begin
            old_cnt = ram_rdata;
        end else begin
            old_cnt = '0;
        end
    end

    // counter update and flags
    always_comb begin
        if (r_s1_down) begin
            n_cnt = {1'b0, old_cnt} + FIRST_COUNT;
            if (n_cnt == RELOAD_COUNT) begin
                n_cnt = RELOAD_COUNT + FIRST_COUNT;
            end
        end else begin
            n_cnt = '0;
        end
        n_rep = (n_cnt != '0) && ((n_cnt == FIRST_COUNT) || (n_cnt > {1'b0, r_delay}));
        if (n_rep && (n_cnt > RELOAD_COUNT)) begin
            n_cnt = RELOAD_COUNT;
        end
        n_pressed = n_cnt != '0;
        n_trig    = n_cnt == FIRST_COUNT;
        n_click   = (old_cnt != '0) && (n_cnt == '0) && r_s1_inside;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    // per-key valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_kvld[k] <= 1'b0;
            end
        end else if (s1_we) begin
            r_kvld[s1_addr] <= 1'b1;
        end
    end

    // update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // update stage payload, forwarding the write of the same edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_key      <= i_key_index;
            r_s1_in_store <= in_store;
            r_s1_down     <= i_key_down && i_has_focus;
            r_s1_inside   <= i_pointer_inside;
            r_s1_kvld     <= r_kvld[in_addr];
            r_s1_fwd      <= s1_we && (s1_addr == in_addr);
            r_s1_fwd_cnt  <= n_cnt[COUNT_W-1:0];
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= r_s1_vld;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_key     <= r_s1_key;
            r_o_pressed <= r_s1_in_store && n_pressed;
            r_o_trig    <= r_s1_in_store && n_trig;
            r_o_rep     <= r_s1_in_store && n_rep;
            r_o_click   <= r_s1_in_store && n_click;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_key_echo  = r_o_key;
    assign o_pressed   = r_o_pressed;
    assign o_triggered = r_o_trig;
    assign o_repeated  = r_o_rep;
    assign o_clicked   = r_o_click;

    // input stalls only behind a pending update
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_vld && r_o_vld && !i_out_ready))
        else $error("input stalled without pending work");

    // an accepted sample always reaches the update stage
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted transaction lost");

    // the stored count never reaches the wrap value
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_we |-> !n_cnt[COUNT_W])
        else $error("hold counter overflow written");

    // flag consistency on the output
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_clicked && o_pressed) && (!o_triggered || o_repeated)
                         && (!o_repeated || o_pressed)))
        else $error("inconsistent key flags");

endmodule

[test/key_flags_checker.sv]
`timescale 1ns / 1ps
// key_flags_checker: per-key hold counter prediction and result comparison
// for key_auto_repeat_tracker_top; depends on kart_pkg only

module key_flags_checker
    import kart_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DELAY_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic               i_key_down,
    input  logic               i_has_focus,
    input  logic               i_pointer_inside,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [KEY_W-1:0]   i_key_echo,
    input  logic               i_pressed,
    input  logic               i_triggered,
    input  logic               i_repeated,
    input  logic               i_clicked,
    output int                 o_fail_count,
    output int                 o_due_count,
    output int                 o_checked_count,
    output int                 o_repeat_count,
    output int                 o_click_count
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             triggered;
        logic             repeated;
        logic             clicked;
    } t_key_flags;

    // own copy of the hold counters and the repeat delay
    logic [COUNT_W-1:0] held_frames [NUM_KEYS];
    logic [DELAY_W-1:0] repeat_delay;
    t_key_flags         flags_due [$];

    // one frame sample: update the key's counter, return its flags
    function automatic t_key_flags advance_key(input logic [KEY_W-1:0] key,
                                               input logic down, input logic focus,
                                               input logic in_area);
        logic [COUNT_W:0] prior;
        logic [COUNT_W:0] count;
        t_key_flags       f;
        f     = '0;
        f.key = key;
        if (int'(key) < NUM_KEYS) begin
            prior = {1'b0, held_frames[key]};
            // held only with focus; counting skips the reload value
            if (down && focus) begin
                count = prior + 1'b1;
                if (count == RELOAD_COUNT)
                    count = RELOAD_COUNT + 1'b1;
            end else begin
                count = '0;
            end
            f.repeated = (count != '0) &&
                         (count == FIRST_COUNT || count > {1'b0, repeat_delay});
            // an auto-repeat past the first frame restarts the count
            if (f.repeated && count > RELOAD_COUNT)
                count = RELOAD_COUNT;
            f.pressed   = count != '0;
            f.triggered = count == FIRST_COUNT;
            f.clicked   = (prior != '0) && (count == '0) && in_area;
            held_frames[key] = count[COUNT_W-1:0];
        end
        return f;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // sample at the falling edge, where every handshake is settled
    always @(negedge i_clk) begin
        t_key_flags want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++)
                held_frames[k] = '0;
            repeat_delay = DELAY_RESET;
            flags_due.delete();
        end else begin
            if (i_cfg_we)
                repeat_delay = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                flags_due.push_back(advance_key(i_key_index, i_key_down, i_has_focus,
                                                i_pointer_inside));
            // output transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (flags_due.size() == 0) begin
                    $error("result for key %0d arrived with nothing expected", i_key_echo);
                    o_fail_count++;
                end else begin
                    want = flags_due.pop_front();
                    check_field("key_echo", want.key, i_key_echo);
                    check_field("pressed", want.pressed, i_pressed);
                    check_field("triggered", want.triggered, i_triggered);
                    check_field("repeated", want.repeated, i_repeated);
                    check_field("clicked", want.clicked, i_clicked);
                    o_checked_count++;
                    if (want.repeated)
                        o_repeat_count++;
                    if (want.clicked)
                        o_click_count++;
                end
            end
        end
        o_due_count = flags_due.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: key sample stimulus, idling, repeat delay settings and verdict
// depends on kart_pkg, key_auto_repeat_tracker_top and key_flags_checker

module tb_top;
    import kart_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STALL_LIMIT     = 3000;
    localparam int TAIL_CYCLES     = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [DELAY_W-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [KEY_W-1:0]   i_key_index;
    logic               i_key_down;
    logic               i_has_focus;
    logic               i_pointer_inside;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [KEY_W-1:0]   o_key_echo;
    logic               o_pressed;
    logic               o_triggered;
    logic               o_repeated;
    logic               o_clicked;

    int fail_count;
    int due_count;
    int checked_count;
    int repeat_count;
    int click_count;

    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_off_asked;
    int               hold_off_served;
    int               cur_delay;
    int               n_sent;
    int               n_settings;
    int               quiet_cycles;
    logic [KEY_W-1:0] key_pool [4];

    key_auto_repeat_tracker_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_key_index      (i_key_index),
        .i_key_down       (i_key_down),
        .i_has_focus      (i_has_focus),
        .i_pointer_inside (i_pointer_inside),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_key_echo       (o_key_echo),
        .o_pressed        (o_pressed),
        .o_triggered      (o_triggered),
        .o_repeated       (o_repeated),
        .o_clicked        (o_clicked)
    );

    key_flags_checker flags_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_key_index      (i_key_index),
        .i_key_down       (i_key_down),
        .i_has_focus      (i_has_focus),
        .i_pointer_inside (i_pointer_inside),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_key_echo       (o_key_echo),
        .i_pressed        (o_pressed),
        .i_triggered      (o_triggered),
        .i_repeated       (o_repeated),
        .i_clicked        (o_clicked),
        .o_fail_count     (fail_count),
        .o_due_count      (due_count),
        .o_checked_count  (checked_count),
        .o_repeat_count   (repeat_count),
        .o_click_count    (click_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        i_out_ready     <= 1'b0;
        hold_off_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_asked != hold_off_served) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_served++;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: cycles in which no transaction moves on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: %0d cycles without a transaction", STALL_LIMIT);
        $display("** key_auto_repeat_tracker_top: FAILED **");
        $finish;
    end

    // one key sample; returns in the step of its acceptance with valid still high
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic down,
                               input logic focus, input logic in_area);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_key_index      <= key;
        i_key_down       <= down;
        i_has_focus      <= focus;
        i_pointer_inside <= in_area;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_noise();
        send_sample(KEY_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // stop offering and wait until every result is back, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cur_delay   = value;
        n_settings++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly held keys from a small pool with releases, the rest random samples
    task automatic run_traffic(input int n);
        int               target;
        int               cap;
        int               len;
        logic [KEY_W-1:0] k;
        target = n_sent + n;
        while (n_sent < target) begin
            if ($urandom_range(99) < 75) begin
                k   = key_pool[$urandom_range(3)];
                cap = (cur_delay > 40) ? 40 : cur_delay + 6;
                len = $urandom_range(cap, 1);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(7) == 0)
                        send_noise();
                    send_sample(k, 1'b1, $urandom_range(19) != 0, 1'($urandom));
                end
                if ($urandom_range(4) != 0)
                    send_sample(k, 1'b0, 1'($urandom), 1'($urandom));
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic run_phase(input logic [DELAY_W-1:0] delay, input int idle_pct,
                             input int stall_pct, input int n);
        write_delay(delay);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < 4; i++)
            key_pool[i] = KEY_W'($urandom);
        run_traffic(n);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        i_in_valid       <= 1'b0;
        i_key_index      <= '0;
        i_key_down       <= 1'b0;
        i_has_focus      <= 1'b0;
        i_pointer_inside <= 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_asked   = 0;
        cur_delay        = DELAY_RESET;
        n_sent           = 0;
        n_settings       = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first frames, clicks, focus loss, extreme keys, back-to-back
        write_delay(DELAY_RESET);
        send_sample(8'd0, 1'b1, 1'b1, 1'b1);
        send_sample(8'd0, 1'b1, 1'b1, 1'b1);
        send_sample(8'd0, 1'b0, 1'b1, 1'b1);
        send_sample(8'd0, 1'b0, 1'b1, 1'b1);
        send_sample(8'd255, 1'b1, 1'b1, 1'b0);
        send_sample(8'd255, 1'b1, 1'b0, 1'b1);
        send_sample(8'd255, 1'b1, 1'b1, 1'b1);
        send_sample(8'd255, 1'b0, 1'b1, 1'b0);
        send_sample(8'd128, 1'b0, 1'b0, 1'b1);
        send_sample(8'd1, 1'b1, 1'b0, 1'b0);
        repeat (4) send_sample(8'd5, 1'b1, 1'b1, 1'b1);
        send_sample(8'd5, 1'b0, 1'b1, 1'b1);
        send_sample(8'd6, 1'b1, 1'b1, 1'b0);
        send_sample(8'd7, 1'b1, 1'b1, 1'b0);
        send_sample(8'd6, 1'b1, 1'b1, 1'b0);
        send_sample(8'd7, 1'b0, 1'b0, 1'b1);

        // delay lowered while a key is held past it
        repeat (8) send_sample(8'd9, 1'b1, 1'b1, 1'b0);
        write_delay(8'd4);
        repeat (2) send_sample(8'd9, 1'b1, 1'b1, 1'b1);
        send_sample(8'd9, 1'b0, 1'b1, 1'b1);

        // random phases over delays and idling patterns
        run_phase(8'd3, 0, 0, 70);
        run_phase(8'd2, 84, 0, 70);
        run_phase(8'd0, 0, 84, 60);
        run_phase(8'd1, 22, 22, 50);
        run_phase(DELAY_RESET, 0, 0, 70);
        run_phase(8'd254, 22, 22, 40);

        // receiver holds off while the sender keeps offering
        run_phase(DELAY_W'($urandom_range(30, 5)), 0, 0, 0);
        hold_off_asked++;
        run_traffic(80);

        // one key held long enough to count through 255 and reload
        run_phase(8'd255, 0, 0, 0);
        repeat (260) send_sample(key_pool[0], 1'b1, 1'b1, 1'b1);
        send_sample(key_pool[0], 1'b0, 1'b1, 1'b1);

        wait_drained();
        $display("%0d key samples over %0d delay settings (0, 1, 2, 254, 255 among them)",
                 n_sent, n_settings);
        $display("%0d results checked, %0d with repeat and %0d with click",
                 checked_count, repeat_count, click_count);
        if (fail_count == 0)
            $display("** key_auto_repeat_tracker_top: PASSED **");
        else
            $display("** key_auto_repeat_tracker_top: FAILED **");
        $finish;
    end

endmodule
